/* hw/rtl/vsd_pkg.sv */
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants for the unsigned LEB128 varint stream decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_W = 7;
    localparam int POS_W     = 4;
    localparam int VALUE_W   = 64;
    localparam int ACC_W     = 63;
    localparam int LEN_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int SHIFT_W   = 7;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

    // position limits within one value
    localparam logic [POS_W-1:0] POS_LAST_DATA = 4'd9;
    localparam logic [POS_W-1:0] POS_OVERRUN   = 4'd10;

    // largest payload a tenth terminating byte may carry
    localparam logic [PAYLOAD_W-1:0] TENTH_MAX = 7'd1;

    localparam int DIGIT_BITS = 7;

    // one classified byte, handed from the front to the back
    typedef struct packed {
        logic                 emit;
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     pos;
        logic [PAYLOAD_W-1:0] payload;
    } vsd_entry_t;

endpackage

/* hw/rtl/vsd_front.sv */
// ----------------------------------------------------------------------------
// vsd_front
// Accept input bytes, track the byte position and classify each byte.
// ----------------------------------------------------------------------------
module vsd_front
    import vsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output vsd_entry_t        q_entry
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             cont;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign cont     = in_byte[BYTE_W-1];

    always_comb
    begin
        q_entry.payload = in_byte[PAYLOAD_W-1:0];
        q_entry.pos     = pos_reg;
        q_entry.emit    = 1'b1;
        q_entry.status  = ST_OK;
        pos_next        = '0;
        if (pos_reg >= POS_OVERRUN)
        begin
            q_entry.status = ST_TOO_LONG;
        end
        else if (!cont)
        begin
            if ((pos_reg == POS_LAST_DATA) && (in_byte[PAYLOAD_W-1:0] > TENTH_MAX))
            begin
                q_entry.status = ST_TOO_BIG;
            end
        end
        else if (in_last)
        begin
            q_entry.status = ST_TRUNC;
        end
        else
        begin
            q_entry.emit = 1'b0;
            pos_next     = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (q_push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* hw/rtl/vsd_queue.sv */
// ----------------------------------------------------------------------------
// vsd_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module vsd_queue
    import vsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vsd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output vsd_entry_t head
);

    vsd_entry_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/vsd_back.sv */
// ----------------------------------------------------------------------------
// vsd_back
// Fold byte payloads into the accumulator and register finished results.
// ----------------------------------------------------------------------------
module vsd_back
    import vsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  vsd_entry_t          q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VALUE_W-1:0]  out_value,
    output logic [LEN_W-1:0]    out_length,
    output logic [STATUS_W-1:0] out_status
);

    logic [ACC_W-1:0]    acc_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SHIFT_W-1:0]  shamt;
    logic [VALUE_W-1:0]  shifted;
    logic                out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = q_not_empty && (!q_head.emit || out_free);
    assign shamt     = SHIFT_W'(q_head.pos) * SHIFT_W'(DIGIT_BITS);
    assign shifted   = {{(VALUE_W-PAYLOAD_W){1'b0}}, q_head.payload} << shamt;

    assign out_valid  = out_valid_reg;
    assign out_value  = value_reg;
    assign out_length = length_reg;
    assign out_status = status_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.emit)
        begin
            value_reg  <= (q_head.status == ST_OK) ? ({1'b0, acc_reg} | shifted) : '0;
            length_reg <= q_head.pos + 1'b1;
            status_reg <= q_head.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                // clear after every result, otherwise merge the next digit
                acc_reg <= q_head.emit ? '0 : (acc_reg | shifted[ACC_W-1:0]);
            end
            if (q_pop && q_head.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/varint_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// varint_stream_decoder_unit
// Streaming decoder for unsigned 64-bit LEB128 varints, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Feed encoded bytes on the s_axis channel, one byte per word, with
//   s_axis_tlast marking the last byte of a buffer. Each finished value, or
//   each error, leaves as one word on the m_axis channel: value and length
//   in m_axis_tdata, status in m_axis_tuser (0 ok, 1 too big, 2 too long,
//   3 truncated). Errors carry value zero; decoding restarts on the next byte.
//   Throughput is one byte per cycle, sustained while the sink takes words.
//   The accepting edge of a terminating byte writes the classify queue;
//   once the byte reaches the head of the queue and the output is free, a
//   later edge carries it through the accumulator into the output register,
//   where its result shows valid.
//   A sink stall holds the output register; the two-entry queue keeps
//   absorbing bytes until it fills, then s_axis_tready drops. Bytes that
//   give no result drain during a stall unless a result waits ahead of them.
//   Reset clears the byte position, accumulator, queue and output valid.
// ----------------------------------------------------------------------------
module varint_stream_decoder_unit
    import vsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] value, [67:64] length, [71:68] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic                q_full;
    logic                q_push;
    vsd_entry_t          q_entry;
    logic                q_pop;
    logic                q_not_empty;
    vsd_entry_t          q_head;
    logic [VALUE_W-1:0]  value;
    logic [LEN_W-1:0]    length;

    // classify each byte as it arrives
    vsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decouple the front from output stalls
    vsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // accumulate digits and hold results for the sink
    vsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (value),
        .out_length  (length),
        .out_status  (m_axis_tuser)
    );

    // pack value and length, pad to whole bytes
    assign m_axis_tdata = {4'b0000, length, value};

endmodule
